[sv/q9_pkg.sv]
package q9_pkg;

   localparam int COORD_W    = 18;
   localparam int VALUE_W    = 20;
   localparam int NODE_W     = 4;
   localparam int NODE_COUNT = 9;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 64;
   localparam int RSP_USER_W = 8;
   localparam int Q_DEPTH    = 2;

   localparam logic [NODE_W-1:0] NODE_LAST = NODE_W'(NODE_COUNT - 1);

   // one-dimensional quadratic factor picked for a node
   typedef enum logic [1:0] {
      FAC_MINUS  = 2'd0,
      FAC_CENTRE = 2'd1,
      FAC_PLUS   = 2'd2
   } fac_type;

   function automatic fac_type node_fac_s(input logic [NODE_W-1:0] node);
      fac_type f;
      case (node)
         4'd0:    f = FAC_MINUS;
         4'd1:    f = FAC_PLUS;
         4'd2:    f = FAC_PLUS;
         4'd3:    f = FAC_MINUS;
         4'd4:    f = FAC_CENTRE;
         4'd5:    f = FAC_PLUS;
         4'd6:    f = FAC_CENTRE;
         4'd7:    f = FAC_MINUS;
         default: f = FAC_CENTRE;
      endcase
      return f;
   endfunction

   function automatic fac_type node_fac_t(input logic [NODE_W-1:0] node);
      fac_type f;
      case (node)
         4'd0:    f = FAC_MINUS;
         4'd1:    f = FAC_MINUS;
         4'd2:    f = FAC_PLUS;
         4'd3:    f = FAC_PLUS;
         4'd4:    f = FAC_MINUS;
         4'd5:    f = FAC_CENTRE;
         4'd6:    f = FAC_PLUS;
         4'd7:    f = FAC_CENTRE;
         default: f = FAC_CENTRE;
      endcase
      return f;
   endfunction

endpackage

[sv/quad9_shape_and_gradient_eval.sv]
// nine-node biquadratic element: shape values and gradients per point
//
// req channel: one transfer per point, s and t in signed Q1.FRAC_BITS,
// clamped to [-1,1]; req_tlast marks the last point of a batch.
// rsp channel: nine transfers per point, nodes 0..8 in order, each with
// the shape value and its s and t derivatives in signed Q3.FRAC_BITS;
// rsp_tlast is set on node 8, rsp_tuser[4] on node 8 of a last point.
// node 0 passes the front pipeline, the queue, and the product and output
// registers; then one node per cycle while rsp_tready stays high.
// the single product stage steps through the nine nodes of the point at
// the queue head and takes a new point only after node 8 has issued.
// the front pipeline and a two-entry queue take new points while the
// back end is busy, so req_tready drops only when both are full.
// a stall on rsp_tready holds the current result and backs up through
// the queue to req_tready.
// reset clears all valid state; no results are pending after reset.
module quad9_shape_and_gradient_eval #(
   parameter int FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // s_coord [17:0], t_coord [35:18], zero pad
   input  logic [q9_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // shape_value [19:0], deriv_s [39:20], deriv_t [59:40], zero pad
   output logic [q9_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // node_index [3:0], batch_end [4], zero pad
   output logic [q9_pkg::RSP_USER_W-1:0]     rsp_tuser,
   output logic                              rsp_tlast
);
   import q9_pkg::*;

   localparam int FW      = FRAC_BITS + 3;
   localparam int ENTRY_W = 12 * FW + 1;

   logic signed [COORD_W-1:0] s_coord, t_coord;
   logic                      q_in_valid, q_in_ready, q_out_valid, q_out_ready;
   logic [ENTRY_W-1:0]        q_in_data, q_out_data;
   logic [NODE_W-1:0]         node_index;
   logic signed [VALUE_W-1:0] shape_value, deriv_s, deriv_t;
   logic                      last_node, batch_end;

   assign s_coord = req_tdata[COORD_W-1:0];
   assign t_coord = req_tdata[2*COORD_W-1:COORD_W];

   q9_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .s_coord    (s_coord),
      .t_coord    (t_coord),
      .last_point (req_tlast),
      .out_valid  (q_in_valid),
      .out_ready  (q_in_ready),
      .out_data   (q_in_data)
   );

   q9_queue #(
      .WIDTH (ENTRY_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_in_valid),
      .in_ready  (q_in_ready),
      .in_data   (q_in_data),
      .out_valid (q_out_valid),
      .out_ready (q_out_ready),
      .out_data  (q_out_data)
   );

   q9_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (q_out_valid),
      .head_ready  (q_out_ready),
      .head_data   (q_out_data),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .node_index  (node_index),
      .shape_value (shape_value),
      .deriv_s     (deriv_s),
      .deriv_t     (deriv_t),
      .last_node   (last_node),
      .batch_end   (batch_end)
   );

   assign rsp_tdata = {{(RSP_DATA_W - 3 * VALUE_W){1'b0}}, deriv_t, deriv_s, shape_value};
   assign rsp_tuser = {{(RSP_USER_W - NODE_W - 1){1'b0}}, batch_end, node_index};
   assign rsp_tlast = last_node;

endmodule

[sv/q9_front.sv]
module q9_front #(
   parameter int FRAC_BITS = 16,
   localparam int FW = FRAC_BITS + 3,
   localparam int ENTRY_W = 12 * FW + 1
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic signed [q9_pkg::COORD_W-1:0]   s_coord,
   input  logic signed [q9_pkg::COORD_W-1:0]   t_coord,
   input  logic                                last_point,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic [ENTRY_W-1:0]                  out_data
);
   import q9_pkg::*;

   localparam int EXT_W = ((FRAC_BITS > COORD_W - 1) ? FRAC_BITS : COORD_W - 1) + 2;
   localparam int SQ_W  = 2 * COORD_W;
   localparam int WW    = ((2 * FRAC_BITS + 3) > (SQ_W + 1)) ? (2 * FRAC_BITS + 3) : (SQ_W + 1);

   localparam logic signed [EXT_W-1:0] ONE_E  = EXT_W'(1) <<< FRAC_BITS;
   localparam logic signed [WW-1:0]    ONE_SQ = WW'(1) <<< (2 * FRAC_BITS);
   localparam logic signed [FW-1:0]    HALF_F = FW'(1) <<< (FRAC_BITS - 1);

   function automatic logic signed [COORD_W-1:0] clamp_coord(
      input logic signed [COORD_W-1:0] c
   );
      logic signed [EXT_W-1:0] e;
      e = EXT_W'(c);
      if (e > ONE_E) begin
         e = ONE_E;
      end else if (e < -ONE_E) begin
         e = -ONE_E;
      end
      return COORD_W'(e);
   endfunction

   // round to nearest, ties away from zero
   function automatic logic signed [WW-1:0] round_q(
      input logic signed [WW-1:0] v,
      input int                   sh
   );
      logic signed [WW-1:0] half;
      logic signed [WW-1:0] sum;
      half = WW'(1) <<< (sh - 1);
      sum  = v + half;
      if (v[WW-1]) begin
         sum = sum - WW'(1);
      end
      return sum >>> sh;
   endfunction

   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic adv1, adv2, adv3;

   logic signed [COORD_W-1:0] xs1_ff, xs1_in, xt1_ff, xt1_in;
   logic                      l1_ff, l1_in;
   logic signed [COORD_W-1:0] xs2_ff, xs2_in, xt2_ff, xt2_in;
   logic signed [SQ_W-1:0]    sqs2_ff, sqs2_in, sqt2_ff, sqt2_in;
   logic                      l2_ff, l2_in;
   logic signed [COORD_W-1:0] xs3_ff, xs3_in, xt3_ff, xt3_in;
   logic signed [WW-1:0]      pms3_ff, pms3_in, lcs3_ff, lcs3_in, pps3_ff, pps3_in;
   logic signed [WW-1:0]      pmt3_ff, pmt3_in, lct3_ff, lct3_in, ppt3_ff, ppt3_in;
   logic                      l3_ff, l3_in;

   logic signed [WW-1:0] sqs_w, sqt_w, xss_w, xts_w;
   logic signed [FW-1:0] vs_m, vs_c, vs_p, ds_m, ds_c, ds_p;
   logic signed [FW-1:0] vt_m, vt_c, vt_p, dt_m, dt_c, dt_p;
   logic signed [FW-1:0] xs_f, xt_f;

   assign adv3     = !v3_ff || out_ready;
   assign adv2     = !v2_ff || adv3;
   assign adv1     = !v1_ff || adv2;
   assign in_ready = adv1;
   assign out_valid = v3_ff;

   // clamp, square, form the raw quadratic factors
   always_comb begin
      v1_in  = adv1 ? in_valid : v1_ff;
      xs1_in = adv1 ? clamp_coord(s_coord) : xs1_ff;
      xt1_in = adv1 ? clamp_coord(t_coord) : xt1_ff;
      l1_in  = adv1 ? last_point : l1_ff;

      v2_in   = adv2 ? v1_ff : v2_ff;
      xs2_in  = adv2 ? xs1_ff : xs2_ff;
      xt2_in  = adv2 ? xt1_ff : xt2_ff;
      sqs2_in = adv2 ? SQ_W'(xs1_ff * xs1_ff) : sqs2_ff;
      sqt2_in = adv2 ? SQ_W'(xt1_ff * xt1_ff) : sqt2_ff;
      l2_in   = adv2 ? l1_ff : l2_ff;

      sqs_w = WW'(sqs2_ff);
      sqt_w = WW'(sqt2_ff);
      xss_w = WW'(xs2_ff) <<< FRAC_BITS;
      xts_w = WW'(xt2_ff) <<< FRAC_BITS;

      v3_in   = adv3 ? v2_ff : v3_ff;
      xs3_in  = adv3 ? xs2_ff : xs3_ff;
      xt3_in  = adv3 ? xt2_ff : xt3_ff;
      pms3_in = adv3 ? (sqs_w - xss_w) : pms3_ff;
      lcs3_in = adv3 ? (ONE_SQ - sqs_w) : lcs3_ff;
      pps3_in = adv3 ? (sqs_w + xss_w) : pps3_ff;
      pmt3_in = adv3 ? (sqt_w - xts_w) : pmt3_ff;
      lct3_in = adv3 ? (ONE_SQ - sqt_w) : lct3_ff;
      ppt3_in = adv3 ? (sqt_w + xts_w) : ppt3_ff;
      l3_in   = adv3 ? l2_ff : l3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      xs1_ff  <= xs1_in;
      xt1_ff  <= xt1_in;
      l1_ff   <= l1_in;
      xs2_ff  <= xs2_in;
      xt2_ff  <= xt2_in;
      sqs2_ff <= sqs2_in;
      sqt2_ff <= sqt2_in;
      l2_ff   <= l2_in;
      xs3_ff  <= xs3_in;
      xt3_ff  <= xt3_in;
      pms3_ff <= pms3_in;
      lcs3_ff <= lcs3_in;
      pps3_ff <= pps3_in;
      pmt3_ff <= pmt3_in;
      lct3_ff <= lct3_in;
      ppt3_ff <= ppt3_in;
      l3_ff   <= l3_in;
   end

   // rounded factor values and exact derivative factors
   always_comb begin
      vs_m = FW'(round_q(pms3_ff, FRAC_BITS + 1));
      vs_c = FW'(round_q(lcs3_ff, FRAC_BITS));
      vs_p = FW'(round_q(pps3_ff, FRAC_BITS + 1));
      vt_m = FW'(round_q(pmt3_ff, FRAC_BITS + 1));
      vt_c = FW'(round_q(lct3_ff, FRAC_BITS));
      vt_p = FW'(round_q(ppt3_ff, FRAC_BITS + 1));
      xs_f = FW'(xs3_ff);
      xt_f = FW'(xt3_ff);
      ds_m = xs_f - HALF_F;
      ds_c = FW'(0) - (xs_f <<< 1);
      ds_p = xs_f + HALF_F;
      dt_m = xt_f - HALF_F;
      dt_c = FW'(0) - (xt_f <<< 1);
      dt_p = xt_f + HALF_F;
      out_data = {l3_ff, dt_p, dt_c, dt_m, vt_p, vt_c, vt_m,
                  ds_p, ds_c, ds_m, vs_p, vs_c, vs_m};
   end

endmodule

[sv/q9_queue.sv]
module q9_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);
   import q9_pkg::*;

   localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int CNT_W = $clog2(Q_DEPTH + 1);

   logic [WIDTH-1:0] entries_ff [Q_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign in_ready  = (count_ff != CNT_W'(Q_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = entries_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

[sv/q9_back.sv]
module q9_back #(
   parameter int FRAC_BITS = 16,
   localparam int FW = FRAC_BITS + 3,
   localparam int ENTRY_W = 12 * FW + 1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               head_valid,
   output logic                               head_ready,
   input  logic [ENTRY_W-1:0]                 head_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [q9_pkg::NODE_W-1:0]          node_index,
   output logic signed [q9_pkg::VALUE_W-1:0]  shape_value,
   output logic signed [q9_pkg::VALUE_W-1:0]  deriv_s,
   output logic signed [q9_pkg::VALUE_W-1:0]  deriv_t,
   output logic                               last_node,
   output logic                               batch_end
);
   import q9_pkg::*;

   localparam int PW = 2 * FW;
   localparam logic signed [PW-1:0] SAT_HI = PW'((2 ** (VALUE_W - 1)) - 1);
   localparam logic signed [PW-1:0] SAT_LO = -PW'(2 ** (VALUE_W - 1));

   // round to nearest, ties away from zero, then saturate
   function automatic logic signed [VALUE_W-1:0] out_q(input logic signed [PW-1:0] p);
      logic signed [PW-1:0] half;
      logic signed [PW-1:0] sum;
      half = PW'(1) <<< (FRAC_BITS - 1);
      sum  = p + half;
      if (p[PW-1]) begin
         sum = sum - PW'(1);
      end
      sum = sum >>> FRAC_BITS;
      if (sum > SAT_HI) begin
         sum = SAT_HI;
      end else if (sum < SAT_LO) begin
         sum = SAT_LO;
      end
      return VALUE_W'(sum);
   endfunction

   logic signed [FW-1:0] vs [3];
   logic signed [FW-1:0] ds [3];
   logic signed [FW-1:0] vt [3];
   logic signed [FW-1:0] dt [3];
   logic                 head_last;

   for (genvar i = 0; i < 3; i++) begin : g_unpack
      assign vs[i] = head_data[i * FW +: FW];
      assign ds[i] = head_data[(3 + i) * FW +: FW];
      assign vt[i] = head_data[(6 + i) * FW +: FW];
      assign dt[i] = head_data[(9 + i) * FW +: FW];
   end
   assign head_last = head_data[ENTRY_W-1];

   logic [NODE_W-1:0] node_ff, node_in;
   logic              adv_p, adv_o, issue, node_done;
   fac_type           sel_s, sel_t;
   logic signed [FW-1:0] a_val, a_der, b_val, b_der;

   logic              p_valid_ff, p_valid_in;
   logic signed [PW-1:0] p_shape_ff, p_shape_in, p_ds_ff, p_ds_in, p_dt_ff, p_dt_in;
   logic [NODE_W-1:0] p_node_ff, p_node_in;
   logic              p_last_ff, p_last_in, p_batch_ff, p_batch_in;

   logic              o_valid_ff, o_valid_in;
   logic signed [VALUE_W-1:0] o_shape_ff, o_shape_in, o_ds_ff, o_ds_in, o_dt_ff, o_dt_in;
   logic [NODE_W-1:0] o_node_ff, o_node_in;
   logic              o_last_ff, o_last_in, o_batch_ff, o_batch_in;

   assign adv_o      = !o_valid_ff || rsp_ready;
   assign adv_p      = !p_valid_ff || adv_o;
   assign issue      = head_valid && adv_p;
   assign node_done  = (node_ff == NODE_LAST);
   assign head_ready = issue && node_done;

   assign sel_s = node_fac_s(node_ff);
   assign sel_t = node_fac_t(node_ff);
   assign a_val = vs[sel_s];
   assign a_der = ds[sel_s];
   assign b_val = vt[sel_t];
   assign b_der = dt[sel_t];

   always_comb begin
      node_in = node_ff;
      if (issue) begin
         node_in = node_done ? '0 : node_ff + NODE_W'(1);
      end

      p_valid_in = adv_p ? head_valid : p_valid_ff;
      p_shape_in = adv_p ? PW'(a_val * b_val) : p_shape_ff;
      p_ds_in    = adv_p ? PW'(a_der * b_val) : p_ds_ff;
      p_dt_in    = adv_p ? PW'(a_val * b_der) : p_dt_ff;
      p_node_in  = adv_p ? node_ff : p_node_ff;
      p_last_in  = adv_p ? node_done : p_last_ff;
      p_batch_in = adv_p ? (node_done && head_last) : p_batch_ff;

      o_valid_in = adv_o ? p_valid_ff : o_valid_ff;
      o_shape_in = adv_o ? out_q(p_shape_ff) : o_shape_ff;
      o_ds_in    = adv_o ? out_q(p_ds_ff) : o_ds_ff;
      o_dt_in    = adv_o ? out_q(p_dt_ff) : o_dt_ff;
      o_node_in  = adv_o ? p_node_ff : o_node_ff;
      o_last_in  = adv_o ? p_last_ff : o_last_ff;
      o_batch_in = adv_o ? p_batch_ff : o_batch_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_ff    <= '0;
         p_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         node_ff    <= node_in;
         p_valid_ff <= p_valid_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_shape_ff <= p_shape_in;
      p_ds_ff    <= p_ds_in;
      p_dt_ff    <= p_dt_in;
      p_node_ff  <= p_node_in;
      p_last_ff  <= p_last_in;
      p_batch_ff <= p_batch_in;
      o_shape_ff <= o_shape_in;
      o_ds_ff    <= o_ds_in;
      o_dt_ff    <= o_dt_in;
      o_node_ff  <= o_node_in;
      o_last_ff  <= o_last_in;
      o_batch_ff <= o_batch_in;
   end

   assign rsp_valid   = o_valid_ff;
   assign node_index  = o_node_ff;
   assign shape_value = o_shape_ff;
   assign deriv_s     = o_ds_ff;
   assign deriv_t     = o_dt_ff;
   assign last_node   = o_last_ff;
   assign batch_end   = o_batch_ff;

endmodule

[tb/quad9_shape_and_gradient_eval_tb.sv]
module quad9_shape_and_gradient_eval_tb;
   import q9_pkg::*;

   localparam int     FB         = 16;
   localparam longint ONE        = 64'sd1 << FB;
   localparam longint HALF       = 64'sd1 << (FB - 1);
   localparam int     RANDOM_PTS = 360;
   localparam int     CALM_TAIL  = 30;
   localparam int     CYCLE_CAP  = 400000;

   typedef struct {
      logic signed [COORD_W-1:0] s_raw;
      logic signed [COORD_W-1:0] t_raw;
      logic                      last;
      bit                        settle;
   } point_type;

   typedef struct {
      logic [NODE_W-1:0]  node;
      logic [VALUE_W-1:0] shape;
      logic [VALUE_W-1:0] slope_s;
      logic [VALUE_W-1:0] slope_t;
      logic               last_node;
      logic               batch_end;
   } node_result_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  rsp_tlast;

   point_type       pending_points[$];
   node_result_type expected_nodes[$];
   point_type       in_flight;
   int           errors       = 0;
   int           points_sent  = 0;
   int           nodes_seen   = 0;
   int           clamped_pts  = 0;
   int           batch_ends   = 0;
   int           cycles       = 0;
   bit           idle_on      = 1'b0;
   bit           wind_down    = 1'b0;
   int           send_gap     = 0;
   int           hold_cnt     = 0;

   quad9_shape_and_gradient_eval #(.FRAC_BITS(FB)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #1 clock = ~clock;

   function automatic longint round_away(input longint v, input int sh);
      longint m;
      m = (v < 0) ? -v : v;
      m = (m + (64'sd1 << (sh - 1))) >>> sh;
      return (v < 0) ? -m : m;
   endfunction

   function automatic longint clamp_coord(input logic signed [COORD_W-1:0] raw);
      longint v;
      v = raw;
      if (v > ONE) v = ONE;
      if (v < -ONE) v = -ONE;
      return v;
   endfunction

   // factor pair per node: corners, edge midpoints, centre
   function automatic fac_type node_factor(input int node, input bit along_t);
      fac_type f;
      case (node)
         0:       f = FAC_MINUS;
         1:       f = along_t ? FAC_MINUS : FAC_PLUS;
         2:       f = FAC_PLUS;
         3:       f = along_t ? FAC_PLUS : FAC_MINUS;
         4:       f = along_t ? FAC_MINUS : FAC_CENTRE;
         5:       f = along_t ? FAC_CENTRE : FAC_PLUS;
         6:       f = along_t ? FAC_PLUS : FAC_CENTRE;
         7:       f = along_t ? FAC_CENTRE : FAC_MINUS;
         default: f = FAC_CENTRE;
      endcase
      return f;
   endfunction

   function automatic longint lagrange_value(input longint x, input fac_type f);
      case (f)
         FAC_MINUS: return round_away(x * (x - ONE), FB + 1);
         FAC_PLUS:  return round_away(x * (x + ONE), FB + 1);
         default:   return round_away(ONE * ONE - x * x, FB);
      endcase
   endfunction

   function automatic longint lagrange_slope(input longint x, input fac_type f);
      case (f)
         FAC_MINUS: return x - HALF;
         FAC_PLUS:  return x + HALF;
         default:   return -2 * x;
      endcase
   endfunction

   function automatic logic [VALUE_W-1:0] scaled_product(input longint a, input longint b);
      longint p;
      p = round_away(a * b, FB);
      if (p > (64'sd1 << (VALUE_W - 1)) - 1) p = (64'sd1 << (VALUE_W - 1)) - 1;
      if (p < -(64'sd1 << (VALUE_W - 1))) p = -(64'sd1 << (VALUE_W - 1));
      return p[VALUE_W-1:0];
   endfunction

   task automatic predict_nodes(input point_type p);
      longint          xs, xt;
      fac_type         fs, ft;
      node_result_type r;
      xs = clamp_coord(p.s_raw);
      xt = clamp_coord(p.t_raw);
      if (xs != p.s_raw || xt != p.t_raw) clamped_pts++;
      if (p.last) batch_ends++;
      for (int k = 0; k < NODE_COUNT; k++) begin
         fs = node_factor(k, 1'b0);
         ft = node_factor(k, 1'b1);
         r.node      = NODE_W'(k);
         r.shape     = scaled_product(lagrange_value(xs, fs), lagrange_value(xt, ft));
         r.slope_s   = scaled_product(lagrange_slope(xs, fs), lagrange_value(xt, ft));
         r.slope_t   = scaled_product(lagrange_value(xs, fs), lagrange_slope(xt, ft));
         r.last_node = (k == NODE_COUNT - 1);
         r.batch_end = (k == NODE_COUNT - 1) && p.last;
         expected_nodes.push_back(r);
      end
   endtask

   task automatic field_check(input string what, input longint want, input longint got);
      if (want != got) begin
         errors++;
         $display("%0t mismatch on %s: expected %0d, actual %0d", $time, what, want, got);
      end
   endtask

   function automatic logic signed [COORD_W-1:0] random_coord();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60)
         return COORD_W'($signed($urandom_range(0, 2 * 65536)) - 65536);
      else if (pick < 75)
         case ($urandom_range(0, 6))
            0:       return COORD_W'(65536);
            1:       return -COORD_W'(65536);
            2:       return COORD_W'(32768);
            3:       return -COORD_W'(32768);
            4:       return COORD_W'(1);
            5:       return -COORD_W'(1);
            default: return '0;
         endcase
      else
         return COORD_W'($urandom());
   endfunction

   task automatic add_point(input logic signed [COORD_W-1:0] s, input logic signed [COORD_W-1:0] t,
                            input logic last, input bit settle);
      point_type p;
      p.s_raw  = s;
      p.t_raw  = t;
      p.last   = last;
      p.settle = settle;
      pending_points.push_back(p);
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles % 48 == 0) idle_on <= ($urandom_range(0, 2) != 0);
      if (cycles > CYCLE_CAP) begin
         $display("FAILURE");
         $finish;
      end
   end

   // point driver
   always @(posedge clock) begin : drive_points
      logic nv;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         nv = req_tvalid;
         if (req_tvalid && req_tready) begin
            predict_nodes(in_flight);
            points_sent++;
            nv = 1'b0;
         end
         wind_down <= (pending_points.size() < CALM_TAIL);
         if (!nv) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (idle_on && !wind_down && $urandom_range(0, 3) == 0) begin
               send_gap = $urandom_range(0, 7);
            end else if (pending_points.size() != 0 &&
                         (!pending_points[0].settle || expected_nodes.size() == 0)) begin
               in_flight = pending_points.pop_front();
               req_tdata <= REQ_DATA_W'({in_flight.t_raw, in_flight.s_raw});
               req_tlast <= in_flight.last;
               nv = 1'b1;
            end
         end
         req_tvalid <= nv;
      end
   end

   // node result monitor
   always @(posedge clock) begin : watch_nodes
      node_result_type want;
      logic            rdy;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_nodes.size() == 0) begin
               errors++;
               $display("%0t unexpected transfer: expected none, actual node %0d",
                        $time, rsp_tuser[NODE_W-1:0]);
            end else begin
               want = expected_nodes.pop_front();
               nodes_seen++;
               field_check("node_index", want.node, rsp_tuser[NODE_W-1:0]);
               field_check("shape_value", $signed(want.shape), $signed(rsp_tdata[19:0]));
               field_check("deriv_s", $signed(want.slope_s), $signed(rsp_tdata[39:20]));
               field_check("deriv_t", $signed(want.slope_t), $signed(rsp_tdata[59:40]));
               field_check("last_node", want.last_node, rsp_tlast);
               field_check("batch_end", want.batch_end, rsp_tuser[4]);
            end
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rdy = 1'b0;
         end else if (idle_on && !wind_down && $urandom_range(0, 3) == 0) begin
            hold_cnt = $urandom_range(0, 7);
            rdy = 1'b0;
         end else begin
            rdy = 1'b1;
         end
         rsp_tready <= rdy;
      end
   end

   initial begin
      // directed: corners, edges, centre, clamping, near-boundary values
      add_point(0, 0, 1'b0, 1'b0);
      add_point(65536, 65536, 1'b0, 1'b0);
      add_point(-65536, -65536, 1'b1, 1'b0);
      add_point(65536, -65536, 1'b0, 1'b0);
      add_point(-65536, 65536, 1'b0, 1'b0);
      add_point(0, 65536, 1'b0, 1'b0);
      add_point(65536, 0, 1'b1, 1'b0);
      add_point(-65536, 0, 1'b0, 1'b0);
      add_point(0, -65536, 1'b0, 1'b0);
      add_point(131071, -131072, 1'b0, 1'b0);
      add_point(-131072, 131071, 1'b1, 1'b0);
      add_point(65537, -65537, 1'b0, 1'b0);
      add_point(-65537, 65537, 1'b0, 1'b0);
      add_point(18'h15555, 18'h2AAAA, 1'b0, 1'b0);
      add_point(18'h2AAAA, 18'h15555, 1'b1, 1'b0);
      add_point(32768, -32768, 1'b0, 1'b0);
      add_point(-32768, 32768, 1'b0, 1'b0);
      add_point(1, -1, 1'b0, 1'b0);
      add_point(-1, 1, 1'b1, 1'b0);
      add_point(65535, -65535, 1'b0, 1'b0);
      add_point(12345, -54321, 1'b1, 1'b0);
      for (int i = 0; i < RANDOM_PTS; i++)
         add_point(random_coord(), random_coord(), ($urandom_range(0, 7) == 0),
                   (i == 0 || i == RANDOM_PTS / 2));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (pending_points.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_nodes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("points sent: %0d (%0d with clamped coordinates, %0d batch ends)",
               points_sent, clamped_pts, batch_ends);
      $display("node results checked: %0d, with random gaps on both channels", nodes_seen);
      if (errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
